/* rtl/admf_pkg.sv */
// Package for the arcade drive mixer filter: register indexes, reset values
// and port constants. No dependencies.
package admf_pkg;

    // Default data path sizes
    localparam int PULSE_BITS_DEF  = 12;
    localparam int ALPHA_SHIFT_DEF = 8;

    // Fixed register field widths
    localparam int DEAD_BAND_BITS = 10;
    localparam int ALPHA_BITS     = 9;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_CENTER = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_BAND    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_MIN    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_MAX    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTH_ALPHA = 3'd4;

    // Register reset values
    localparam int RST_PULSE_CENTER = 1500;
    localparam int RST_DEAD_BAND    = 50;
    localparam int RST_PULSE_MIN    = 1000;
    localparam int RST_PULSE_MAX    = 2000;
    localparam int RST_SMOOTH_ALPHA = 64;

endpackage

/* rtl/admf_if.sv */
// Channel interfaces: command input, drive result output, register writes.
// Depends on admf_pkg.
interface admf_cmd_if
    import admf_pkg::*;
#(
    parameter int PULSE_BITS = PULSE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PULSE_BITS-1:0] throttle_pulse;
    logic [PULSE_BITS-1:0] steering_pulse;

    modport source (output valid, throttle_pulse, steering_pulse, input ready);
    modport sink   (input valid, throttle_pulse, steering_pulse, output ready);
endinterface

interface admf_drive_if
    import admf_pkg::*;
#(
    parameter int PULSE_BITS = PULSE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PULSE_BITS-1:0] left_drive;
    logic [PULSE_BITS-1:0] right_drive;
    logic [PULSE_BITS-1:0] left_smoothed;
    logic [PULSE_BITS-1:0] right_smoothed;

    modport source (output valid, left_drive, right_drive, left_smoothed,
                    right_smoothed, input ready);
    modport sink   (input valid, left_drive, right_drive, left_smoothed,
                    right_smoothed, output ready);
endinterface

interface admf_cfg_if
    import admf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/admf_mix.sv */
// Mixer: centers throttle and steering, applies the input deadband, forms
// left/right sums and maps them to stop, clamp or pass. Uses admf_pkg.
module admf_mix
    import admf_pkg::*;
#(
    parameter int PULSE_BITS = PULSE_BITS_DEF
) (
    input  logic [PULSE_BITS-1:0]     i_throttle,
    input  logic [PULSE_BITS-1:0]     i_steering,
    input  logic [PULSE_BITS-1:0]     i_center,
    input  logic [DEAD_BAND_BITS-1:0] i_band,
    input  logic [PULSE_BITS-1:0]     i_min,
    input  logic [PULSE_BITS-1:0]     i_max,
    output logic [PULSE_BITS-1:0]     o_left,
    output logic [PULSE_BITS-1:0]     o_right
);

    // Signed width with headroom for center +/- band and the two sums
    localparam int SW = ((PULSE_BITS > DEAD_BAND_BITS) ? PULSE_BITS : DEAD_BAND_BITS) + 4;

    logic signed [SW-1:0] w_c;
    logic signed [SW-1:0] w_b;
    logic signed [SW-1:0] w_min;
    logic signed [SW-1:0] w_max;
    logic signed [SW-1:0] w_lo;
    logic signed [SW-1:0] w_hi;
    logic signed [SW-1:0] w_thr;
    logic signed [SW-1:0] w_ste;
    logic signed [SW-1:0] w_thr_z;
    logic signed [SW-1:0] w_ste_z;
    logic signed [SW-1:0] w_sum_l;
    logic signed [SW-1:0] w_sum_r;

    // Stop zone first, then low clamp, then high clamp
    function automatic logic [PULSE_BITS-1:0] limit_drive(
        input logic signed [SW-1:0] v,
        input logic signed [SW-1:0] lo,
        input logic signed [SW-1:0] hi,
        input logic signed [SW-1:0] vmin,
        input logic signed [SW-1:0] vmax
    );
        logic [PULSE_BITS-1:0] res;
        if (v >= lo && v <= hi) begin
            res = '0;
        end else if (v < vmin) begin
            res = vmin[PULSE_BITS-1:0];
        end else if (v > vmax) begin
            res = vmax[PULSE_BITS-1:0];
        end else begin
            res = v[PULSE_BITS-1:0];
        end
        return res;
    endfunction

    // Extend register values into the signed domain
    assign w_c   = SW'(i_center);
    assign w_b   = SW'(i_band);
    assign w_min = SW'(i_min);
    assign w_max = SW'(i_max);
    assign w_lo  = w_c - w_b;
    assign w_hi  = w_c + w_b;

    // Center the commands and zero anything strictly inside the band
    assign w_thr   = SW'(i_throttle) - w_c;
    assign w_ste   = SW'(i_steering) - w_c;
    assign w_thr_z = (w_thr > -w_b && w_thr < w_b) ? '0 : w_thr;
    assign w_ste_z = (w_ste > -w_b && w_ste < w_b) ? '0 : w_ste;

    // Differential mix, re-centered
    assign w_sum_l = w_thr_z + w_ste_z + w_c;
    assign w_sum_r = w_thr_z - w_ste_z + w_c;

    assign o_left  = limit_drive(w_sum_l, w_lo, w_hi, w_min, w_max);
    assign o_right = limit_drive(w_sum_r, w_lo, w_hi, w_min, w_max);

endmodule

/* rtl/arcade_drive_mixer_filter.sv */
// A command transaction accepted into the input stage register is loaded into the
// result register and is then offered on the drive output.
// Throughput: one transaction per clock while the output is not stalled; the filter
// feedback closes within the result stage. A stalled output holds while one more command waits.
// Reset (synchronous, active low): registers take their defaults, filters clear
// to zero, both pipeline stages empty. Uses admf_pkg, admf_if.sv and admf_mix.
module arcade_drive_mixer_filter
    import admf_pkg::*;
#(
    parameter int PULSE_BITS  = PULSE_BITS_DEF,
    parameter int ALPHA_SHIFT = ALPHA_SHIFT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    admf_cfg_if.sink     i_cfg,
    admf_cmd_if.sink     i_cmd,
    admf_drive_if.source o_drive
);

    localparam int AW = ALPHA_SHIFT + 1;
    localparam int CW = (AW > ALPHA_BITS) ? AW : ALPHA_BITS;
    localparam int PW = PULSE_BITS + AW + 1;
    localparam logic [AW-1:0] ALPHA_ONE = AW'(1) << ALPHA_SHIFT;

    // Configuration registers
    logic [PULSE_BITS-1:0]     r_center;
    logic [DEAD_BAND_BITS-1:0] r_band;
    logic [PULSE_BITS-1:0]     r_min;
    logic [PULSE_BITS-1:0]     r_max;
    logic [ALPHA_BITS-1:0]     r_alpha;

    // Input stage
    logic                  r_in_valid;
    logic [PULSE_BITS-1:0] r_in_thr;
    logic [PULSE_BITS-1:0] r_in_ste;

    // Result stage and filter state
    logic                  r_out_valid;
    logic [PULSE_BITS-1:0] r_left;
    logic [PULSE_BITS-1:0] r_right;
    logic [PULSE_BITS-1:0] r_left_filt;
    logic [PULSE_BITS-1:0] r_right_filt;
    logic [PULSE_BITS-1:0] n_left_filt;
    logic [PULSE_BITS-1:0] n_right_filt;

    logic                  w_out_free;
    logic                  w_move;
    logic [AW-1:0]         w_alpha;
    logic [PULSE_BITS-1:0] w_left;
    logic [PULSE_BITS-1:0] w_right;

    // First-order low-pass step
    function automatic logic [PULSE_BITS-1:0] smooth(
        input logic [PULSE_BITS-1:0] x,
        input logic [PULSE_BITS-1:0] prev,
        input logic [AW-1:0]         a
    );
        logic [PW-1:0] acc;
        acc = PW'(x) * PW'(a) + PW'(prev) * PW'(ALPHA_ONE - a);
        return acc[ALPHA_SHIFT +: PULSE_BITS];
    endfunction

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= PULSE_BITS'(RST_PULSE_CENTER);
            r_band   <= DEAD_BAND_BITS'(RST_DEAD_BAND);
            r_min    <= PULSE_BITS'(RST_PULSE_MIN);
            r_max    <= PULSE_BITS'(RST_PULSE_MAX);
            r_alpha  <= ALPHA_BITS'(RST_SMOOTH_ALPHA);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PULSE_CENTER: r_center <= i_cfg.data[PULSE_BITS-1:0];
                REG_DEAD_BAND:    r_band   <= i_cfg.data[DEAD_BAND_BITS-1:0];
                REG_PULSE_MIN:    r_min    <= i_cfg.data[PULSE_BITS-1:0];
                REG_PULSE_MAX:    r_max    <= i_cfg.data[PULSE_BITS-1:0];
                REG_SMOOTH_ALPHA: r_alpha  <= i_cfg.data[ALPHA_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign w_out_free  = !r_out_valid || o_drive.ready;
    assign w_move      = r_in_valid && w_out_free;
    assign i_cmd.ready = !r_in_valid || w_out_free;

    // Capture command transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_thr <= i_cmd.throttle_pulse;
            r_in_ste <= i_cmd.steering_pulse;
        end
    end

    // Mix, deadband and clamp
    admf_mix #(
        .PULSE_BITS (PULSE_BITS)
    ) u_mix (
        .i_throttle (r_in_thr),
        .i_steering (r_in_ste),
        .i_center   (r_center),
        .i_band     (r_band),
        .i_min      (r_min),
        .i_max      (r_max),
        .o_left     (w_left),
        .o_right    (w_right)
    );

    // Saturate alpha at unity, then filter
    assign w_alpha      = (CW'(r_alpha) > CW'(ALPHA_ONE)) ? ALPHA_ONE : AW'(r_alpha);
    assign n_left_filt  = smooth(w_left, r_left_filt, w_alpha);
    assign n_right_filt = smooth(w_right, r_right_filt, w_alpha);

    // Result register and filter state advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_left_filt  <= '0;
            r_right_filt <= '0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_move) begin
                r_left_filt  <= n_left_filt;
                r_right_filt <= n_right_filt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_left  <= w_left;
            r_right <= w_right;
        end
    end

    assign o_drive.valid          = r_out_valid;
    assign o_drive.left_drive     = r_left;
    assign o_drive.right_drive    = r_right;
    assign o_drive.left_smoothed  = r_left_filt;
    assign o_drive.right_smoothed = r_right_filt;

endmodule

/* bench/testbench.sv */
// Testbench for arcade_drive_mixer_filter: directed and random command transactions
// checked against a bit-accurate predictor of the mix, stop zone, clamp and filters.
// Depends on admf_pkg, the channel interfaces in rtl/admf_if.sv and the RTL top level.
module testbench
    import admf_pkg::*;
();

    localparam int PB         = PULSE_BITS_DEF;
    localparam int ALPHA_ONE  = 1 << ALPHA_SHIFT_DEF;
    localparam int PULSE_TOP  = (1 << PB) - 1;
    localparam int SETTLE     = 4;
    localparam int MAX_REPORT = 10;

    // Index that maps to no register
    localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 3'd7;

    typedef logic [PB-1:0] t_pulse;

    typedef struct packed {
        t_pulse left_drive;
        t_pulse right_drive;
        t_pulse left_smoothed;
        t_pulse right_smoothed;
    } t_drive_result;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic i_clk;
    logic i_rst_n;

    admf_cfg_if   cfg_bus();
    admf_cmd_if   cmd_bus();
    admf_drive_if drive_bus();

    arcade_drive_mixer_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_cmd   (cmd_bus),
        .o_drive (drive_bus)
    );

    // Shadow registers and filter state of the predictor
    int     shadow_center;
    int     shadow_band;
    int     shadow_min;
    int     shadow_max;
    int     shadow_alpha;
    t_pulse left_filter;
    t_pulse right_filter;

    t_drive_result drive_expected[$];

    int send_idle_pct;
    int sink_stall_pct;
    int sink_hold_cycles;
    int mismatch_count;
    int command_count;
    int result_count;
    int cfg_write_count;

    // Clock: period 10
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Stop zone, then clamp to [min, max] in that order
    function automatic int limit_drive(int v);
        if (v >= shadow_center - shadow_band && v <= shadow_center + shadow_band)
            return 0;
        if (v < shadow_min)
            return shadow_min;
        if (v > shadow_max)
            return shadow_max;
        return v;
    endfunction

    function automatic t_pulse low_pass(t_pulse x, t_pulse prev);
        int a;
        int y;
        a = (shadow_alpha > ALPHA_ONE) ? ALPHA_ONE : shadow_alpha;
        y = (a * int'(x) + (ALPHA_ONE - a) * int'(prev)) >>> ALPHA_SHIFT_DEF;
        return t_pulse'(y & PULSE_TOP);
    endfunction

    // Mix one command into drive values and advance both filters
    function automatic t_drive_result mix_command(t_pulse throttle, t_pulse steering);
        t_drive_result r;
        int thr;
        int ste;
        thr = int'(throttle) - shadow_center;
        ste = int'(steering) - shadow_center;
        if (thr > -shadow_band && thr < shadow_band)
            thr = 0;
        if (ste > -shadow_band && ste < shadow_band)
            ste = 0;
        r.left_drive     = t_pulse'(limit_drive(thr + ste + shadow_center) & PULSE_TOP);
        r.right_drive    = t_pulse'(limit_drive(thr - ste + shadow_center) & PULSE_TOP);
        left_filter      = low_pass(r.left_drive, left_filter);
        right_filter     = low_pass(r.right_drive, right_filter);
        r.left_smoothed  = left_filter;
        r.right_smoothed = right_filter;
        return r;
    endfunction

    function automatic void note_mismatch(string what, int exp_val, int act_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORT)
            $display("MISMATCH result %0d %s: expected %0d actual %0d",
                     result_count, what, exp_val, act_val);
    endfunction

    // Receiver: long hold-off when asked, otherwise random stalls
    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            drive_bus.ready = 1'b0;
            sink_hold_cycles--;
        end else begin
            drive_bus.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_drive_result want;
        if (i_rst_n && drive_bus.valid && drive_bus.ready) begin
            if (drive_expected.size() == 0) begin
                note_mismatch("with nothing expected, left_drive", -1,
                              int'(drive_bus.left_drive));
            end else begin
                want = drive_expected.pop_front();
                if (drive_bus.left_drive !== want.left_drive)
                    note_mismatch("left_drive", want.left_drive, drive_bus.left_drive);
                if (drive_bus.right_drive !== want.right_drive)
                    note_mismatch("right_drive", want.right_drive, drive_bus.right_drive);
                if (drive_bus.left_smoothed !== want.left_smoothed)
                    note_mismatch("left_smoothed", want.left_smoothed,
                                  drive_bus.left_smoothed);
                if (drive_bus.right_smoothed !== want.right_smoothed)
                    note_mismatch("right_smoothed", want.right_smoothed,
                                  drive_bus.right_smoothed);
            end
            result_count++;
        end
    end

    // Offer one command; entered and left at a falling edge
    task automatic send_command(t_pulse throttle, t_pulse steering);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge i_clk);
        cmd_bus.valid          = 1'b1;
        cmd_bus.throttle_pulse = throttle;
        cmd_bus.steering_pulse = steering;
        do @(posedge i_clk); while (!cmd_bus.ready);
        drive_expected.push_back(mix_command(throttle, steering));
        command_count++;
        @(negedge i_clk);
        cmd_bus.valid = 1'b0;
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index, int value);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = index;
        cfg_bus.data  = CFG_DATA_BITS'(value);
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (index)
            REG_PULSE_CENTER: shadow_center = value & PULSE_TOP;
            REG_DEAD_BAND:    shadow_band   = value & ((1 << DEAD_BAND_BITS) - 1);
            REG_PULSE_MIN:    shadow_min    = value & PULSE_TOP;
            REG_PULSE_MAX:    shadow_max    = value & PULSE_TOP;
            REG_SMOOTH_ALPHA: shadow_alpha  = value & ((1 << ALPHA_BITS) - 1);
            default: ;
        endcase
        cfg_write_count++;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic write_settings(int center, int band, int lo, int hi, int alpha);
        write_register(REG_PULSE_CENTER, center);
        write_register(REG_DEAD_BAND, band);
        write_register(REG_PULSE_MIN, lo);
        write_register(REG_PULSE_MAX, hi);
        write_register(REG_SMOOTH_ALPHA, alpha);
    endtask

    // Hold until every expected result has arrived, then let the pipeline settle
    task automatic wait_for_results();
        while (drive_expected.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_idling(t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 45; sink_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  sink_stall_pct = 45; end
            default:       begin send_idle_pct = 38; sink_stall_pct = 38; end
        endcase
    endtask

    // Pulse value: full range, near the center, or on or next to a stop zone edge
    function automatic t_pulse pick_pulse();
        int kind;
        int v;
        kind = $urandom_range(99);
        if (kind < 40) begin
            v = $urandom_range(PULSE_TOP);
        end else if (kind < 80) begin
            v = shadow_center + $urandom_range(4 * shadow_band + 400)
                - (2 * shadow_band + 200);
        end else begin
            v = shadow_center + (($urandom_range(1) != 0) ? shadow_band : -shadow_band)
                + $urandom_range(2) - 1;
        end
        if (v < 0)
            v = 0;
        if (v > PULSE_TOP)
            v = PULSE_TOP;
        return t_pulse'(v);
    endfunction

    // Random register settings with the extremes mixed in
    task automatic write_random_settings();
        int center;
        int band;
        int lo;
        int hi;
        int alpha;
        int pick;
        pick   = $urandom_range(3);
        center = (pick == 0) ? 0 : (pick == 1) ? PULSE_TOP : $urandom_range(PULSE_TOP);
        pick   = $urandom_range(4);
        band   = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(200);
        lo     = $urandom_range(PULSE_TOP);
        hi     = $urandom_range(PULSE_TOP);
        // Mostly a proper window, sometimes min above max
        if ($urandom_range(3) != 0 && lo > hi) begin
            pick = lo;
            lo   = hi;
            hi   = pick;
        end
        if ($urandom_range(5) == 0) begin
            lo = 0;
            hi = PULSE_TOP;
        end
        pick  = $urandom_range(4);
        alpha = (pick == 0) ? 0 : (pick == 1) ? ALPHA_ONE :
                (pick == 2) ? (1 << ALPHA_BITS) - 1 : $urandom_range((1 << ALPHA_BITS) - 1);
        write_settings(center, band, lo, hi, alpha);
    endtask

    // Reset values: neutral, full-range corners and both stop zone edges
    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        send_command(12'd1500, 12'd1500);
        send_command(12'd0, 12'd0);
        send_command(12'd4095, 12'd4095);
        send_command(12'd4095, 12'd0);
        send_command(12'd0, 12'd4095);
        send_command(12'd1549, 12'd1500);
        send_command(12'd1550, 12'd1500);
        send_command(12'd1551, 12'd1500);
        send_command(12'd1451, 12'd1500);
        send_command(12'd1450, 12'd1449);
        send_command(12'd1600, 12'd1700);
        send_command(12'd2000, 12'd1000);
        wait_for_results();
    endtask

    // Register extremes: zone below zero, min above max, alpha at 0, 256 and above
    task automatic test_register_extremes();
        write_settings(0, 1023, 0, PULSE_TOP, ALPHA_ONE);
        write_register(REG_NONE, 16'hFFFF);
        send_command(12'd0, 12'd0);
        send_command(12'd4095, 12'd4095);
        send_command(12'd1023, 12'd0);
        send_command(12'd1024, 12'd4095);
        wait_for_results();
        write_settings(PULSE_TOP, 0, 3000, 500, (1 << ALPHA_BITS) - 1);
        send_command(12'd4095, 12'd4095);
        send_command(12'd0, 12'd0);
        send_command(12'd0, 12'd4095);
        wait_for_results();
        write_settings(2048, 10, PULSE_TOP, 0, 0);
        send_command(12'd2100, 12'd2000);
        send_command(12'd4095, 12'd0);
        wait_for_results();
    endtask

    // Random commands under each idling pattern, two settings per pattern
    task automatic test_random_phases();
        for (int mode = IDLE_NONE; mode <= IDLE_BOTH; mode++) begin
            set_idling(t_idle_mode'(mode));
            for (int part = 0; part < 2; part++) begin
                wait_for_results();
                write_random_settings();
                repeat (150) send_command(pick_pulse(), pick_pulse());
            end
        end
        wait_for_results();
    endtask

    // Receiver holds off while commands keep coming; then batches with both sides idling and with none
    task automatic test_backpressure();
        write_settings(RST_PULSE_CENTER, RST_DEAD_BAND, RST_PULSE_MIN, RST_PULSE_MAX,
                       RST_SMOOTH_ALPHA);
        set_idling(IDLE_NONE);
        sink_hold_cycles = 200;
        repeat (40) send_command(pick_pulse(), pick_pulse());
        wait_for_results();
        set_idling(IDLE_BOTH);
        repeat (40) send_command(pick_pulse(), pick_pulse());
        wait_for_results();
        set_idling(IDLE_NONE);
        repeat (40) send_command(pick_pulse(), pick_pulse());
        wait_for_results();
    endtask

    initial begin
        i_rst_n                = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.throttle_pulse = '0;
        cmd_bus.steering_pulse = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
        drive_bus.ready        = 1'b0;
        send_idle_pct          = 0;
        sink_stall_pct         = 0;
        sink_hold_cycles       = 0;
        mismatch_count         = 0;
        command_count          = 0;
        result_count           = 0;
        cfg_write_count        = 0;
        shadow_center          = RST_PULSE_CENTER;
        shadow_band            = RST_DEAD_BAND;
        shadow_min             = RST_PULSE_MIN;
        shadow_max             = RST_PULSE_MAX;
        shadow_alpha           = RST_SMOOTH_ALPHA;
        left_filter            = '0;
        right_filter           = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_phases();
        test_backpressure();

        $display("Covered %0d commands, %0d results, %0d register writes, %0d mismatches",
                 command_count, result_count, cfg_write_count, mismatch_count);
        $display("Phases: reset defaults, register extremes, four idling patterns, hold-off");
        if (mismatch_count == 0 && drive_expected.size() == 0)
            $display("arcade_drive_mixer_filter test passed");
        else
            $display("arcade_drive_mixer_filter test failed");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2000000;
        $display("arcade_drive_mixer_filter test failed");
        $finish;
    end

endmodule
